// ===== rtl/pph_pkg.sv =====
// ----------------------------------------------------------------------------
// pph_pkg
// Shared types, codes and lookup functions of the per-position histogram.
// ----------------------------------------------------------------------------
package pph_pkg;

   localparam logic [1:0] OP_ADD_BASE  = 2'd0;
   localparam logic [1:0] OP_READ_NT   = 2'd1;
   localparam logic [1:0] OP_READ_QUAL = 2'd2;

   localparam int NT_CODES = 17;
   localparam int CODE_W   = 5;

   typedef struct packed {
      logic [1:0] opcode;
      logic [7:0] base_char;
      logic [7:0] quality_char;
      logic       has_quality;
      logic       end_of_read;
      logic [7:0] query_position;
      logic [6:0] query_bin;
   } req_type;

   typedef struct packed {
      logic [31:0] count_value;
      logic [8:0]  longest_read;
      logic        unknown_base;
      logic        quality_out_of_range;
      logic        position_overflow;
   } rsp_type;

   typedef struct packed {
      logic clear;
      logic capture;
      logic read;
      logic update;
   } ctl_cmd_type;

   typedef struct packed {
      logic clear_last;
   } dp_status_type;

   function automatic logic [CODE_W-1:0] iupac_code(input logic [7:0] ch);
      logic [CODE_W-1:0] code;
      code = '0;
      unique case (ch)
         8'h2D, 8'h2E: code = 5'd16;
         8'h41, 8'h61: code = 5'd1;
         8'h42, 8'h62: code = 5'd14;
         8'h43, 8'h63: code = 5'd2;
         8'h44, 8'h64: code = 5'd13;
         8'h47, 8'h67: code = 5'd4;
         8'h48, 8'h68: code = 5'd11;
         8'h4B, 8'h6B: code = 5'd12;
         8'h4D, 8'h6D: code = 5'd3;
         8'h4E, 8'h6E: code = 5'd15;
         8'h52, 8'h72: code = 5'd5;
         8'h53, 8'h73: code = 5'd6;
         8'h54, 8'h74: code = 5'd8;
         8'h56, 8'h76: code = 5'd7;
         8'h57, 8'h77: code = 5'd9;
         8'h59, 8'h79: code = 5'd10;
         default:      code = 5'd0;
      endcase
      return code;
   endfunction

   // lowest raw character of the scheme range: offset plus minimum
   function automatic logic [6:0] scheme_base(input logic [1:0] qtype);
      logic [6:0] b;
      unique case (qtype)
         2'd0:    b = 7'd4;
         2'd1:    b = 7'd33;
         2'd2:    b = 7'd59;
         default: b = 7'd64;
      endcase
      return b;
   endfunction

   // maximum minus minimum
   function automatic logic [6:0] scheme_span(input logic [1:0] qtype);
      logic [6:0] s;
      unique case (qtype)
         2'd0:    s = 7'd56;
         2'd1:    s = 7'd93;
         2'd2:    s = 7'd67;
         default: s = 7'd62;
      endcase
      return s;
   endfunction

endpackage

// ===== rtl/pph_ctrl.sv =====
// ----------------------------------------------------------------------------
// pph_ctrl
// Sequencer: clearing sweep after reset, then capture, read, update per
// transaction.
// ----------------------------------------------------------------------------
module pph_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   input  pph_pkg::dp_status_type status,
   output pph_pkg::ctl_cmd_type   cmd,
   output logic                   busy
);

   typedef enum logic [1:0] {
      S_CLEAR,
      S_IDLE,
      S_READ,
      S_UPDATE
   } state_type;

   state_type state_ff, state_in;
   logic      busy_ff, busy_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_CLEAR:  if (status.clear_last) state_in = S_IDLE;
         S_IDLE:   if (start) state_in = S_READ;
         S_READ:   state_in = S_UPDATE;
         S_UPDATE: state_in = S_IDLE;
         default:  state_in = S_CLEAR;
      endcase
      busy_in = (state_in != S_IDLE);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         busy_ff  <= 1'b1;
      end else begin
         state_ff <= state_in;
         busy_ff  <= busy_in;
      end
   end

   assign cmd.clear   = (state_ff == S_CLEAR);
   assign cmd.capture = (state_ff == S_IDLE) && start;
   assign cmd.read    = (state_ff == S_READ);
   assign cmd.update  = (state_ff == S_UPDATE);
   assign busy        = busy_ff;

endmodule

// ===== rtl/pph_dp.sv =====
// ----------------------------------------------------------------------------
// pph_dp
// Datapath: count memories, position tracking, scheme register, result.
// ----------------------------------------------------------------------------
module pph_dp #(
   parameter int MAX_POSITIONS = 256,
   parameter int QUALITY_BINS  = 128,
   parameter int COUNT_BITS    = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  pph_pkg::ctl_cmd_type   cmd,
   output pph_pkg::dp_status_type status,
   input  pph_pkg::req_type       req,
   input  logic                   csr_valid,
   input  logic [1:0]             csr_data,
   output logic                   rsp_strobe,
   output pph_pkg::rsp_type       rsp
);

   localparam int PW   = $clog2(MAX_POSITIONS + 1);
   localparam int AWP  = $clog2(MAX_POSITIONS);
   localparam int QBW  = $clog2(QUALITY_BINS);
   localparam int NTAW = AWP + pph_pkg::CODE_W;
   localparam int QAW  = AWP + QBW;

   logic [COUNT_BITS-1:0] nt_mem [2**NTAW];
   logic [COUNT_BITS-1:0] q_mem  [2**QAW];

   pph_pkg::req_type      req_ff;
   logic [PW-1:0]         pos_ff, pos_in;
   logic [PW-1:0]         max_ff, max_in;
   logic [1:0]            qtype_ff;
   logic [QAW-1:0]        clr_ff;
   logic                  strobe_ff;
   pph_pkg::rsp_type      rsp_ff, rsp_in;

   logic [COUNT_BITS-1:0] nt_rd_ff, q_rd_ff;
   logic [NTAW-1:0]       nt_addr, nt_addr_ff;
   logic [QAW-1:0]        q_addr, q_addr_ff;
   logic                  pos_ok, pos_ok_ff;
   logic                  qual_ok, qual_ok_ff;
   logic                  rd_ok, rd_ok_ff;
   logic                  unknown_base_ff;
   logic                  qual_bad, qual_bad_ff;

   logic [pph_pkg::CODE_W-1:0] code;
   logic [8:0]            qdiff;
   logic [6:0]            qbase, qspan;
   logic [AWP-1:0]        pidx;
   logic [QBW-1:0]        qbin;
   logic                  qpos_ok;
   logic [COUNT_BITS-1:0] nt_new, q_new;
   logic                  nt_we, q_we;

   always_comb begin
      code    = pph_pkg::iupac_code(req_ff.base_char);
      qbase   = pph_pkg::scheme_base(qtype_ff);
      qspan   = pph_pkg::scheme_span(qtype_ff);
      qdiff   = {1'b0, req_ff.quality_char} - {2'b00, qbase};
      pos_ok  = (pos_ff < PW'(MAX_POSITIONS));
      qpos_ok = (32'(req_ff.query_position) < 32'(MAX_POSITIONS));
      qual_bad = req_ff.has_quality &&
                 (qdiff[8] || (qdiff > {2'b00, qspan}) ||
                  (32'(qdiff) >= 32'(QUALITY_BINS)));
      qual_ok = (req_ff.opcode == pph_pkg::OP_ADD_BASE) && req_ff.has_quality &&
                !qual_bad && pos_ok;
      if (req_ff.opcode == pph_pkg::OP_ADD_BASE) begin
         pidx = AWP'(pos_ff);
         qbin = QBW'(qdiff);
         nt_addr = {pidx, code};
         rd_ok = pos_ok;
      end else begin
         pidx = AWP'(req_ff.query_position);
         qbin = QBW'(req_ff.query_bin);
         nt_addr = {pidx, pph_pkg::CODE_W'(req_ff.query_bin)};
         if (req_ff.opcode == pph_pkg::OP_READ_NT)
            rd_ok = qpos_ok && (32'(req_ff.query_bin) < 32'(pph_pkg::NT_CODES));
         else
            rd_ok = qpos_ok && (32'(req_ff.query_bin) < 32'(QUALITY_BINS));
      end
      q_addr = {pidx, qbin};
   end

   assign nt_new = (nt_rd_ff == '1) ? nt_rd_ff : nt_rd_ff + 1'b1;
   assign q_new  = (q_rd_ff == '1) ? q_rd_ff : q_rd_ff + 1'b1;
   assign nt_we  = cmd.update && (req_ff.opcode == pph_pkg::OP_ADD_BASE) && pos_ok_ff;
   assign q_we   = cmd.update && qual_ok_ff;

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         if (clr_ff[QAW-1:NTAW] == '0) nt_mem[clr_ff[NTAW-1:0]] <= '0;
      end else if (nt_we) begin
         nt_mem[nt_addr_ff] <= nt_new;
      end
      if (cmd.read) nt_rd_ff <= nt_mem[nt_addr];
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         q_mem[clr_ff] <= '0;
      end else if (q_we) begin
         q_mem[q_addr_ff] <= q_new;
      end
      if (cmd.read) q_rd_ff <= q_mem[q_addr];
   end

   always_comb begin
      pos_in = pos_ff;
      max_in = max_ff;
      rsp_in = '0;
      if (req_ff.opcode == pph_pkg::OP_ADD_BASE) begin
         if (pos_ok_ff) begin
            if (pos_ff + 1'b1 > max_ff) max_in = pos_ff + 1'b1;
         end else begin
            max_in = PW'(MAX_POSITIONS);
         end
         if (req_ff.end_of_read) pos_in = '0;
         else if (pos_ok_ff) pos_in = pos_ff + 1'b1;
         rsp_in.unknown_base         = unknown_base_ff;
         rsp_in.quality_out_of_range = qual_bad_ff;
         rsp_in.position_overflow    = !pos_ok_ff;
         if (pos_ok_ff) rsp_in.count_value = 32'(nt_new);
      end else if (rd_ok_ff) begin
         if (req_ff.opcode == pph_pkg::OP_READ_NT) rsp_in.count_value = 32'(nt_rd_ff);
         else if (req_ff.opcode == pph_pkg::OP_READ_QUAL)
            rsp_in.count_value = 32'(q_rd_ff);
      end
      rsp_in.longest_read = 9'(max_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff    <= '0;
         max_ff    <= '0;
         qtype_ff  <= 2'd1;
         clr_ff    <= '0;
         strobe_ff <= 1'b0;
      end else begin
         if (csr_valid) qtype_ff <= csr_data;
         if (cmd.clear) clr_ff <= clr_ff + 1'b1;
         if (cmd.update) begin
            pos_ff <= pos_in;
            max_ff <= max_in;
         end
         strobe_ff <= cmd.update;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) req_ff <= req;
      if (cmd.read) begin
         nt_addr_ff      <= nt_addr;
         q_addr_ff       <= q_addr;
         pos_ok_ff       <= pos_ok;
         qual_ok_ff      <= qual_ok;
         rd_ok_ff        <= rd_ok;
         unknown_base_ff <= (code == '0);
         qual_bad_ff     <= qual_bad;
      end
      if (cmd.update) rsp_ff <= rsp_in;
   end

   assign status.clear_last = (clr_ff == '1);
   assign rsp_strobe        = strobe_ff;
   assign rsp               = rsp_ff;

endmodule

// ===== rtl/per_position_base_quality_histogram.sv =====
// ----------------------------------------------------------------------------
// per_position_base_quality_histogram
// Per-position nucleotide and quality histogram of streamed read bases.
// ----------------------------------------------------------------------------
// Each transaction passes through capture, memory read and update before the
// rsp_strobe pulse; busy stays high meanwhile, so a new transaction is only
// accepted once the last one is done. The result is shown for one cycle only
// and the receiver cannot stall it. After reset, busy stays high while both
// count memories are swept to zero; csr writes are taken always.
module per_position_base_quality_histogram #(
   parameter int MAX_POSITIONS = 256,
   parameter int QUALITY_BINS  = 128,
   parameter int COUNT_BITS    = 32
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  pph_pkg::req_type  req,
   output logic              rsp_strobe,
   output pph_pkg::rsp_type  rsp,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [1:0]        csr_data
);

   pph_pkg::ctl_cmd_type   cmd;
   pph_pkg::dp_status_type status;

   pph_ctrl u_ctrl (
      .clock  (clock),
      .reset  (reset),
      .start  (start),
      .status (status),
      .cmd    (cmd),
      .busy   (busy)
   );

   pph_dp #(
      .MAX_POSITIONS (MAX_POSITIONS),
      .QUALITY_BINS  (QUALITY_BINS),
      .COUNT_BITS    (COUNT_BITS)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req        (req),
      .csr_valid  (csr_valid),
      .csr_data   (csr_data),
      .rsp_strobe (rsp_strobe),
      .rsp        (rsp)
   );

   assign csr_ready = 1'b1;

endmodule

// ===== rtl/pph_checker.sv =====
// ----------------------------------------------------------------------------
// pph_checker
// Port-level checks of the histogram block, bound to the top level.
// ----------------------------------------------------------------------------
module pph_checker (
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_strobe,
   input pph_pkg::rsp_type rsp
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("busy not raised after accepted transaction");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      start && !busy |-> ##3 rsp_strobe)
      else $error("result not delivered three cycles after accept");

   a_strobe_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> !busy)
      else $error("result strobe while busy");

   a_overflow_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp.position_overflow |-> rsp.count_value == 32'd0)
      else $error("count reported for overflowed position");

endmodule

bind per_position_base_quality_histogram pph_checker u_pph_checker (
   .clock      (clock),
   .reset      (reset),
   .start      (start),
   .busy       (busy),
   .rsp_strobe (rsp_strobe),
   .rsp        (rsp)
);

// ===== sim/testbench.sv =====
// ----------------------------------------------------------------------------
// Per-position histogram testbench
// Drives base, read-back and unused transactions into the histogram block,
// predicts every result from a model of the count stores, and compares each
// strobed result field by field. The quality scheme is changed between phases.
// ----------------------------------------------------------------------------
module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_POS   = 256;
   localparam int QBINS     = 128;
   localparam int LIMIT_CYC = 2_000_000;
   localparam int REQ_W     = $bits(pph_pkg::req_type);
   localparam logic [159:0] BASE_SET = "ACGTacgtRYSWKMBDHVn.";
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic [1:0] QT_PHRED = 2'd0, QT_SANGER = 2'd1, QT_SOLEXA = 2'd2,
                          QT_ILLUMINA = 2'd3;

   logic clock, reset, start, busy, rsp_strobe, csr_valid, csr_ready;
   logic [1:0] csr_data;
   pph_pkg::req_type req;
   pph_pkg::rsp_type rsp;

   per_position_base_quality_histogram dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy), .req(req),
      .rsp_strobe(rsp_strobe), .rsp(rsp), .csr_valid(csr_valid),
      .csr_ready(csr_ready), .csr_data(csr_data)
   );

   logic [31:0] nt_hist [MAX_POS*pph_pkg::NT_CODES];
   logic [31:0] qual_hist [MAX_POS*QBINS];
   int unsigned read_pos, longest_len;
   logic [1:0] scheme;
   pph_pkg::rsp_type pending_rsp [$];
   int errors, sent, checked, bases, cycles;

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYC) begin
         $display("per_position_base_quality_histogram verification failed");
         $finish;
      end
   end

   function automatic logic [4:0] nt_code(input logic [7:0] ch);
      case (ch)
         "-", ".": return 5'd16;
         "A", "a": return 5'd1;
         "C", "c": return 5'd2;
         "M", "m": return 5'd3;
         "G", "g": return 5'd4;
         "R", "r": return 5'd5;
         "S", "s": return 5'd6;
         "V", "v": return 5'd7;
         "T", "t": return 5'd8;
         "W", "w": return 5'd9;
         "Y", "y": return 5'd10;
         "H", "h": return 5'd11;
         "K", "k": return 5'd12;
         "D", "d": return 5'd13;
         "B", "b": return 5'd14;
         "N", "n": return 5'd15;
         default:  return 5'd0;
      endcase
   endfunction

   function automatic logic [31:0] bump(input logic [31:0] c);
      return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
   endfunction

   function automatic pph_pkg::rsp_type histogram_update(input pph_pkg::req_type r);
      pph_pkg::rsp_type o;
      int off, qmin, qmax, q;
      int unsigned pos, ni;
      logic [4:0] code;
      o = '0;
      case (r.opcode)
         pph_pkg::OP_ADD_BASE: begin
            pos = read_pos;
            code = nt_code(r.base_char);
            o.unknown_base = (code == 0);
            case (scheme)
               QT_PHRED:  begin off = 0;  qmin = 4;  qmax = 60; end
               QT_SANGER: begin off = 33; qmin = 0;  qmax = 93; end
               QT_SOLEXA: begin off = 64; qmin = -5; qmax = 62; end
               default:   begin off = 64; qmin = 0;  qmax = 62; end
            endcase
            if (r.has_quality) begin
               q = int'(r.quality_char) - off;
               if (q < qmin || q > qmax || (q - qmin) >= QBINS)
                  o.quality_out_of_range = 1'b1;
               else if (pos < MAX_POS)
                  qual_hist[pos*QBINS + q - qmin] = bump(qual_hist[pos*QBINS + q - qmin]);
            end
            if (pos < MAX_POS) begin
               ni = pos*pph_pkg::NT_CODES + code;
               nt_hist[ni] = bump(nt_hist[ni]);
               o.count_value = nt_hist[ni];
               if (pos + 1 > longest_len) longest_len = pos + 1;
            end else begin
               o.position_overflow = 1'b1;
               longest_len = MAX_POS;
            end
            if (r.end_of_read) read_pos = 0;
            else if (pos < MAX_POS) read_pos = pos + 1;
         end
         pph_pkg::OP_READ_NT: begin
            if (r.query_bin < pph_pkg::NT_CODES)
               o.count_value = nt_hist[r.query_position*pph_pkg::NT_CODES + r.query_bin];
         end
         pph_pkg::OP_READ_QUAL: begin
            o.count_value = qual_hist[r.query_position*QBINS + r.query_bin];
         end
         default: ;
      endcase
      o.longest_read = longest_len[8:0];
      return o;
   endfunction

   always @(posedge clock) begin
      pph_pkg::rsp_type want;
      if (!reset && rsp_strobe) begin
         if (pending_rsp.size() == 0) begin
            errors++;
            $display("%0t: unexpected result %h", $realtime, rsp);
         end else begin
            want = pending_rsp.pop_front();
            checked++;
            if (rsp.count_value !== want.count_value)
               $display("%0t: count_value expected %0d actual %0d", $realtime,
                        want.count_value, rsp.count_value);
            if (rsp.longest_read !== want.longest_read)
               $display("%0t: longest_read expected %0d actual %0d", $realtime,
                        want.longest_read, rsp.longest_read);
            if (rsp.unknown_base !== want.unknown_base)
               $display("%0t: unknown_base expected %b actual %b", $realtime,
                        want.unknown_base, rsp.unknown_base);
            if (rsp.quality_out_of_range !== want.quality_out_of_range)
               $display("%0t: quality_out_of_range expected %b actual %b", $realtime,
                        want.quality_out_of_range, rsp.quality_out_of_range);
            if (rsp.position_overflow !== want.position_overflow)
               $display("%0t: position_overflow expected %b actual %b", $realtime,
                        want.position_overflow, rsp.position_overflow);
            if (rsp !== want) errors++;
         end
      end
   end

   task automatic send_item(input pph_pkg::req_type r, input bit gaps);
      int gap;
      gap = gaps ? $urandom_range(13) : 0;
      repeat (gap + 1) @(negedge clock);
      start <= 1'b1;
      req <= r;
      do @(posedge clock); while (busy);
      pending_rsp.push_back(histogram_update(r));
      sent++;
      if (r.opcode == pph_pkg::OP_ADD_BASE) bases++;
      @(negedge clock);
      start <= 1'b0;
      req <= pph_pkg::req_type'(REQ_W'({$urandom, $urandom}));
   endtask

   task automatic write_scheme(input logic [1:0] value);
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      scheme = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   function automatic pph_pkg::req_type base_item(input logic [7:0] ch,
                                                  input logic [7:0] qc,
                                                  input bit hq, input bit eor);
      pph_pkg::req_type r;
      r = pph_pkg::req_type'(REQ_W'({$urandom, $urandom}));
      r.opcode = pph_pkg::OP_ADD_BASE;
      r.base_char = ch;
      r.quality_char = qc;
      r.has_quality = hq;
      r.end_of_read = eor;
      return r;
   endfunction

   function automatic pph_pkg::req_type query_item(input logic [1:0] op,
                                                   input logic [7:0] p,
                                                   input logic [6:0] b);
      pph_pkg::req_type r;
      r = pph_pkg::req_type'(REQ_W'({$urandom, $urandom}));
      r.opcode = op;
      r.query_position = p;
      r.query_bin = b;
      return r;
   endfunction

   function automatic logic [7:0] pick_base();
      case ($urandom_range(9))
         0:       return 8'($urandom);
         1:       return "-";
         2:       return "N";
         default: return BASE_SET[$urandom_range(19)*8 +: 8];
      endcase
   endfunction

   task automatic test_directed();
      send_item(base_item("A", 8'd33, 1, 0), 0);
      send_item(base_item(".", 8'd126, 1, 0), 0);
      send_item(base_item("-", 8'd32, 1, 0), 0);
      send_item(base_item(8'hFF, 8'd127, 1, 0), 0);
      send_item(base_item(8'h00, 8'hFF, 1, 0), 0);
      send_item(base_item("n", 8'h00, 0, 1), 0);
      send_item(base_item("y", 8'd33, 1, 1), 0);
      send_item(query_item(pph_pkg::OP_READ_NT, 8'd0, 7'd1), 0);
      send_item(query_item(pph_pkg::OP_READ_NT, 8'd0, 7'd16), 0);
      send_item(query_item(pph_pkg::OP_READ_NT, 8'd1, 7'd17), 0);
      send_item(query_item(pph_pkg::OP_READ_NT, 8'd255, 7'd127), 0);
      send_item(query_item(pph_pkg::OP_READ_QUAL, 8'd0, 7'd0), 0);
      send_item(query_item(pph_pkg::OP_READ_QUAL, 8'd1, 7'd93), 0);
      send_item(query_item(pph_pkg::OP_READ_QUAL, 8'd255, 7'd127), 0);
      send_item(query_item(OP_UNUSED, 8'd0, 7'd0), 0);
   endtask

   task automatic test_long_read();
      for (int i = 0; i < MAX_POS + 3; i++)
         send_item(base_item(pick_base(), 8'($urandom_range(33, 126)),
                             1, i == MAX_POS + 2), i % 7 == 0);
      send_item(query_item(pph_pkg::OP_READ_NT, 8'd255, 7'($urandom_range(16))), 0);
   endtask

   task automatic test_saturation_spot();
      // hammer one cell to verify repeated counting at position 0
      for (int i = 0; i < 20; i++)
         send_item(base_item("G", 8'd64, 1, 1), i < 10);
      send_item(query_item(pph_pkg::OP_READ_NT, 8'd0, 7'd4), 0);
      send_item(query_item(pph_pkg::OP_READ_QUAL, 8'd0, 7'd0), 0);
   endtask

   task automatic test_random(input int n);
      pph_pkg::req_type r;
      int len;
      bit gaps;
      while (n > 0) begin
         gaps = $urandom_range(3) != 0;
         len = $urandom_range(1, 12);
         if ($urandom_range(3) != 0) begin
            for (int i = 0; i < len; i++) begin
               r = base_item(pick_base(), 8'($urandom_range(28, 130)),
                             $urandom_range(7) != 0, i == len - 1);
               if ($urandom_range(15) == 0) r.quality_char = 8'($urandom);
               send_item(r, gaps);
            end
            n -= len;
         end else begin
            for (int i = 0; i < len; i++) begin
               r = query_item(2'($urandom_range(1, 3)), 8'($urandom_range(15)),
                              7'($urandom_range(4) == 0 ? $urandom : $urandom_range(20)));
               if ($urandom_range(9) == 0) r.query_position = 8'($urandom);
               send_item(r, gaps);
            end
            n -= len;
         end
      end
   endtask

   initial begin
      reset = 1'b1;
      start = 1'b0;
      req = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      errors = 0; sent = 0; checked = 0; bases = 0; cycles = 0;
      read_pos = 0; longest_len = 0; scheme = QT_SANGER;
      foreach (nt_hist[i]) nt_hist[i] = '0;
      foreach (qual_hist[i]) qual_hist[i] = '0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      write_scheme(QT_PHRED);
      test_directed();
      test_random(90);
      write_scheme(QT_SOLEXA);
      test_saturation_spot();
      test_random(90);
      write_scheme(QT_ILLUMINA);
      test_random(90);
      write_scheme(QT_SANGER);
      test_long_read();
      test_random(90);
      write_scheme(QT_PHRED);
      test_random(60);
      while (pending_rsp.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      $display("Covered %0d transactions (%0d bases) across all four quality schemes,",
               sent, bases);
      $display("including a read past the stored positions; %0d results compared.", checked);
      if (errors == 0)
         $display("per_position_base_quality_histogram verification clean");
      else
         $display("per_position_base_quality_histogram verification failed");
      $finish;
   end

endmodule
